FILE: hdl/circular_list_with_cursor_core_defines.svh
// ----------------------------------------------------------------------------
// circular list with cursor - assertion macros
// shared concurrent assertion forms, clocked on clk, held off during reset
// ----------------------------------------------------------------------------
`ifndef CIRCULAR_LIST_WITH_CURSOR_CORE_DEFINES_SVH
`define CIRCULAR_LIST_WITH_CURSOR_CORE_DEFINES_SVH

// same-cycle implication
`define CLWC_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("clwc same-cycle check failed");

// next-cycle implication
`define CLWC_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("clwc next-cycle check failed");

`endif

FILE: hdl/clwc_pkg.sv
// ----------------------------------------------------------------------------
// clwc_pkg
// types, codes and sizes shared by the circular list with cursor block
// ----------------------------------------------------------------------------
package clwc_pkg;

  localparam int DEPTH  = 16;
  localparam int IDX_W  = $clog2(DEPTH);
  localparam int CNT_W  = 5;
  localparam int DATA_W = 32;
  localparam int FUNC_W = 3;
  localparam int STAT_W = 2;

  // operation codes
  localparam logic [FUNC_W-1:0] F_INS_TAIL = 3'd0;
  localparam logic [FUNC_W-1:0] F_INS_HEAD = 3'd1;
  localparam logic [FUNC_W-1:0] F_FIRST    = 3'd2;
  localparam logic [FUNC_W-1:0] F_NEXT     = 3'd3;
  localparam logic [FUNC_W-1:0] F_REMOVE   = 3'd4;

  // status codes
  localparam logic [STAT_W-1:0] S_OK     = 2'd0;
  localparam logic [STAT_W-1:0] S_EMPTY  = 2'd1;
  localparam logic [STAT_W-1:0] S_FULL   = 2'd2;
  localparam logic [STAT_W-1:0] S_NO_CUR = 2'd3;

  typedef struct packed {
    logic [FUNC_W-1:0]        func;
    logic signed [DATA_W-1:0] value;
  } in_item_t;

  typedef struct packed {
    logic [STAT_W-1:0]        status;
    logic signed [DATA_W-1:0] data_out;
    logic [CNT_W-1:0]         count;
  } out_item_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic link_step;
    logic finish;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic out_free;
  } sts_t;

endpackage

FILE: hdl/clwc_ctrl.sv
// ----------------------------------------------------------------------------
// clwc_ctrl
// sequencer: accept, link read/first write, finish and result load
// ----------------------------------------------------------------------------
module clwc_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  clwc_pkg::sts_t sts,
  output clwc_pkg::cmd_t cmd
);
  import clwc_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_LINK = 2'd1;
  localparam logic [1:0] ST_FIN  = 2'd2;

  logic [1:0] state_r;
  logic [1:0] state_nxt;

  always_comb begin
    state_nxt     = state_r;
    cmd.load      = 1'b0;
    cmd.link_step = 1'b0;
    cmd.finish    = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_LINK;
        end
      end
      ST_LINK: begin
        cmd.link_step = 1'b1;
        state_nxt     = ST_FIN;
      end
      ST_FIN: begin
        // wait here while the result register is still occupied
        if (sts.out_free) begin
          cmd.finish = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign in_stall = (state_r != ST_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

FILE: hdl/clwc_dpath.sv
// ----------------------------------------------------------------------------
// clwc_dpath
// node memories, free slot stack, list pointers and result register
// ----------------------------------------------------------------------------
module clwc_dpath (
  input  logic                clk,
  input  logic                rst_n,
  input  clwc_pkg::cmd_t      cmd,
  output clwc_pkg::sts_t      sts,
  input  clwc_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output clwc_pkg::out_item_t out_data
);
  import clwc_pkg::*;

  // node memories
  logic [DATA_W-1:0] val_mem [DEPTH];
  logic [IDX_W-1:0]  link_mem [DEPTH];

  logic              val_we, val_re;
  logic [IDX_W-1:0]  val_waddr, val_raddr;
  logic [DATA_W-1:0] val_q;
  logic              link_we;
  logic [IDX_W-1:0]  link_waddr, link_wdata;
  logic [IDX_W-1:0]  link_tail_q, link_cur_q;

  // latched request
  logic [FUNC_W-1:0]  func_r;
  logic [DATA_W-1:0]  value_r;

  // list state
  logic [IDX_W-1:0]  free_stack_r [DEPTH];
  logic [CNT_W-1:0]  ftop_r, ftop_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [IDX_W-1:0]  tail_r, tail_nxt;
  logic [IDX_W-1:0]  cur_r, cur_nxt;
  logic [IDX_W-1:0]  bef_r, bef_nxt;
  logic              cvalid_r, cvalid_nxt;
  logic              ralw_r, ralw_nxt;
  logic              out_valid_r;
  out_item_t         out_r;

  logic              empty, full, is_ins;
  logic              ins_ok, first_ok, next_ok, rem_ok;
  logic [STAT_W-1:0] status;
  logic [CNT_W-1:0]  ftop_m1;
  logic [IDX_W-1:0]  new_slot;
  logic              push_ok;

  assign empty    = (cnt_r == '0);
  assign full     = (cnt_r == CNT_W'(DEPTH)) || (ftop_r == '0);
  assign is_ins   = (func_r == F_INS_TAIL) || (func_r == F_INS_HEAD);
  assign ftop_m1  = ftop_r - CNT_W'(1);
  assign new_slot = free_stack_r[ftop_m1[IDX_W-1:0]];
  assign push_ok  = (ftop_r < CNT_W'(DEPTH));

  // operation decode against the current list state
  always_comb begin
    status   = S_OK;
    ins_ok   = 1'b0;
    first_ok = 1'b0;
    next_ok  = 1'b0;
    rem_ok   = 1'b0;
    if (is_ins) begin
      if (full) status = S_FULL;
      else      ins_ok = 1'b1;
    end else if (func_r == F_FIRST) begin
      if (empty) status   = S_EMPTY;
      else       first_ok = 1'b1;
    end else if (func_r == F_NEXT) begin
      if (empty)          status  = S_EMPTY;
      else if (!cvalid_r) status  = S_NO_CUR;
      else                next_ok = 1'b1;
    end else if (func_r == F_REMOVE) begin
      if (empty)                     status = S_EMPTY;
      else if (!cvalid_r || !ralw_r) status = S_NO_CUR;
      else                           rem_ok = 1'b1;
    end
  end

  // memory port control
  always_comb begin
    val_we     = 1'b0;
    val_waddr  = new_slot;
    val_re     = 1'b0;
    val_raddr  = cur_r;
    link_we    = 1'b0;
    link_waddr = new_slot;
    link_wdata = link_tail_q;
    if (cmd.load) begin
      val_re = 1'b1;
    end else if (cmd.link_step) begin
      if (ins_ok) begin
        val_we     = 1'b1;
        link_we    = 1'b1;
        link_wdata = empty ? new_slot : link_tail_q;
      end
      if (rem_ok) begin
        link_we    = 1'b1;
        link_waddr = bef_r;
        link_wdata = link_cur_q;
      end
      if (first_ok) begin
        val_re    = 1'b1;
        val_raddr = link_tail_q;
      end
      if (next_ok) begin
        val_re    = 1'b1;
        val_raddr = link_cur_q;
      end
    end else if (cmd.finish) begin
      // second link write of a non-empty insert
      if (ins_ok && !empty) begin
        link_we    = 1'b1;
        link_waddr = tail_r;
        link_wdata = new_slot;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (val_we) val_mem[val_waddr] <= value_r;
    if (val_re) val_q <= val_mem[val_raddr];
  end

  always_ff @(posedge clk) begin
    if (link_we) link_mem[link_waddr] <= link_wdata;
    if (cmd.load) begin
      link_tail_q <= link_mem[tail_r];
      link_cur_q  <= link_mem[cur_r];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      func_r  <= in_data.func;
      value_r <= in_data.value;
    end
  end

  // pointer updates, applied at finish
  always_comb begin
    ftop_nxt   = ftop_r;
    cnt_nxt    = cnt_r;
    tail_nxt   = tail_r;
    cur_nxt    = cur_r;
    bef_nxt    = bef_r;
    cvalid_nxt = cvalid_r;
    ralw_nxt   = ralw_r;
    if (ins_ok) begin
      ftop_nxt = ftop_m1;
      cnt_nxt  = cnt_r + CNT_W'(1);
      ralw_nxt = 1'b0;
      if (empty || (func_r == F_INS_TAIL)) tail_nxt = new_slot;
    end
    if (first_ok) begin
      bef_nxt    = tail_r;
      cur_nxt    = link_tail_q;
      cvalid_nxt = 1'b1;
      ralw_nxt   = 1'b1;
    end
    if (next_ok) begin
      bef_nxt  = cur_r;
      cur_nxt  = link_cur_q;
      ralw_nxt = 1'b1;
    end
    if (rem_ok) begin
      if (cur_r == tail_r) tail_nxt = bef_r;
      cur_nxt  = bef_r;
      if (push_ok) ftop_nxt = ftop_r + CNT_W'(1);
      cnt_nxt  = cnt_r - CNT_W'(1);
      ralw_nxt = 1'b0;
      if (cnt_r == CNT_W'(1)) begin
        cvalid_nxt = 1'b0;
        tail_nxt   = '0;
        cur_nxt    = '0;
        bef_nxt    = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ftop_r   <= CNT_W'(DEPTH);
      cnt_r    <= '0;
      tail_r   <= '0;
      cur_r    <= '0;
      bef_r    <= '0;
      cvalid_r <= 1'b0;
      ralw_r   <= 1'b0;
    end else if (cmd.finish) begin
      ftop_r   <= ftop_nxt;
      cnt_r    <= cnt_nxt;
      tail_r   <= tail_nxt;
      cur_r    <= cur_nxt;
      bef_r    <= bef_nxt;
      cvalid_r <= cvalid_nxt;
      ralw_r   <= ralw_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < DEPTH; i++) begin
        free_stack_r[i] <= IDX_W'(DEPTH - 1 - i);
      end
    end else if (cmd.finish && rem_ok && push_ok) begin
      free_stack_r[ftop_r[IDX_W-1:0]] <= cur_r;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.finish) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_r.status   <= status;
      out_r.data_out <= (first_ok || next_ok || rem_ok) ? val_q : '0;
      out_r.count    <= cnt_nxt;
    end
  end

  assign sts.out_free = !out_valid_r || !out_stall;
  assign out_valid    = out_valid_r;
  assign out_data     = out_r;

endmodule

FILE: hdl/circular_list_with_cursor_core.sv
// ----------------------------------------------------------------------------
// circular_list_with_cursor_core
// 16-entry circular singly linked list of 32-bit values with a cursor
// ----------------------------------------------------------------------------
// usage
//   in_valid / in_stall / in_data carry one request: func picks insert at
//   tail, insert at head, cursor to head, advance cursor or remove at cursor;
//   value is the element for inserts and is ignored otherwise
//   out_valid / out_stall / out_data return exactly one result per request:
//   status (ok, empty, full, no cursor), data_out and the element count
// sequencing
//   a request passes accept (link and value read), link step
//   (dependent node read, first link write) and finish (second link write,
//   pointer update, result load); out_valid rises the cycle after finish;
//   a new request is taken only once the last one finishes; the steps are
//   set by the single link write port and dependent link-then-value read
// reset
//   a synchronous rst_n low empties the list, fills the free slot stack and
//   drops the cursor; the node memories are not cleared
// stall
//   the result register holds while out_stall is high; a new request is
//   still taken, and its finish waits until the register frees up
// ----------------------------------------------------------------------------
module circular_list_with_cursor_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  clwc_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output clwc_pkg::out_item_t out_data
);
  import clwc_pkg::*;

  // command and status between sequencer and datapath
  cmd_t cmd;
  sts_t sts;

  // sequencer: one request in flight at a time
  clwc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  // datapath: memories, list pointers, free stack and result register
  clwc_dpath u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

FILE: hdl/clwc_checker.sv
// ----------------------------------------------------------------------------
// clwc_checker
// port-level checks on the circular list with cursor block
// ----------------------------------------------------------------------------
`include "circular_list_with_cursor_core_defines.svh"

module clwc_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_stall,
  input logic                out_valid,
  input logic                out_stall,
  input clwc_pkg::out_item_t out_data
);
  import clwc_pkg::*;

  // one request in flight: busy right after an accept
  `CLWC_ASSERT_NXT(a_busy_after_accept, in_valid && !in_stall, in_stall)

  // a full answer only comes with every slot in use
  `CLWC_ASSERT_IMP(a_full_count, out_valid && (out_data.status == S_FULL),
                   out_data.count == CNT_W'(DEPTH))

  // an empty answer shows no elements and no data
  `CLWC_ASSERT_IMP(a_empty_zero, out_valid && (out_data.status == S_EMPTY),
                   (out_data.count == '0) && (out_data.data_out == '0))

  // a stalled result holds
  `CLWC_ASSERT_NXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data))

endmodule

bind circular_list_with_cursor_core clwc_checker u_clwc_checker (.*);

FILE: verif/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top - circular list with cursor regression
// drives list operations through the request channel under several idle and
// stall mixes, predicts every result with a cycle-free list model and checks
// status, value and element count in order
// ----------------------------------------------------------------------------
module tb_top;
  import clwc_pkg::*;

  localparam int CYCLE_LIMIT = 300000;
  localparam int TAIL_WAIT   = 20;

  // random generator moods
  localparam int MODE_MIXED = 0;
  localparam int MODE_FILL  = 1;
  localparam int MODE_DRAIN = 2;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_data;

  circular_list_with_cursor_core u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // requests waiting to be driven, results waiting to come back
  in_item_t  pending_requests[$];
  out_item_t expected_results[$];

  // idle mix of the current phase, in percent
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;

  int unsigned fail_count     = 0;
  int unsigned requests_taken = 0;
  int unsigned results_seen   = 0;
  int unsigned full_answers   = 0;
  int unsigned cursor_answers = 0;
  int unsigned cycle_count    = 0;

  // list model: node store, free slot stack, tail and cursor pair
  logic [DATA_W-1:0] node_val   [DEPTH];
  logic [IDX_W-1:0]  node_nxt   [DEPTH];
  logic [IDX_W-1:0]  free_slots [DEPTH];
  int                free_top;
  int                list_len;
  logic [IDX_W-1:0]  tail_ptr;
  logic [IDX_W-1:0]  cur_ptr;
  logic [IDX_W-1:0]  prev_ptr;
  logic              cur_ok;
  logic              may_remove;

  // apply one list operation to the model and return the answer it gives
  function automatic out_item_t predict_list_op(in_item_t req);
    out_item_t        res;
    logic [IDX_W-1:0] slot_n;
    res = '0;
    case (req.func)
      F_INS_TAIL, F_INS_HEAD: begin
        if (list_len >= DEPTH || free_top == 0) begin
          res.status = S_FULL;
        end else begin
          free_top--;
          slot_n = free_slots[free_top];
          node_val[slot_n] = req.value;
          if (list_len == 0) begin
            // a lone node links to itself
            node_nxt[slot_n] = slot_n;
            tail_ptr = slot_n;
          end else begin
            // splice in after the tail; only a tail insert moves the tail
            node_nxt[slot_n] = node_nxt[tail_ptr];
            node_nxt[tail_ptr] = slot_n;
            if (req.func == F_INS_TAIL) tail_ptr = slot_n;
          end
          list_len++;
          may_remove = 1'b0;
        end
      end
      F_FIRST: begin
        if (list_len == 0) begin
          res.status = S_EMPTY;
        end else begin
          prev_ptr = tail_ptr;
          cur_ptr = node_nxt[tail_ptr];
          cur_ok = 1'b1;
          may_remove = 1'b1;
          res.data_out = node_val[cur_ptr];
        end
      end
      F_NEXT: begin
        if (list_len == 0) begin
          res.status = S_EMPTY;
        end else if (!cur_ok) begin
          res.status = S_NO_CUR;
        end else begin
          prev_ptr = cur_ptr;
          cur_ptr = node_nxt[cur_ptr];
          may_remove = 1'b1;
          res.data_out = node_val[cur_ptr];
        end
      end
      F_REMOVE: begin
        if (list_len == 0) begin
          res.status = S_EMPTY;
        end else if (!cur_ok || !may_remove) begin
          res.status = S_NO_CUR;
        end else begin
          slot_n = cur_ptr;
          res.data_out = node_val[slot_n];
          if (slot_n == tail_ptr) tail_ptr = prev_ptr;
          node_nxt[prev_ptr] = node_nxt[slot_n];
          cur_ptr = prev_ptr;
          if (free_top < DEPTH) begin
            free_slots[free_top] = slot_n;
            free_top++;
          end
          list_len--;
          may_remove = 1'b0;
          if (list_len == 0) begin
            // last node gone: cursor drops and pointers go back to zero
            cur_ok = 1'b0;
            tail_ptr = '0;
            cur_ptr = '0;
            prev_ptr = '0;
          end
        end
      end
      default: ;  // unused codes leave everything alone
    endcase
    res.count = CNT_W'(list_len);
    return res;
  endfunction

  // values lean toward the sign, zero and all-ones corners now and then
  function automatic logic [DATA_W-1:0] random_value();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 3) return 32'h8000_0000;
    if (pick < 6) return 32'h7fff_ffff;
    if (pick < 8) return 32'h0000_0000;
    if (pick < 10) return 32'hffff_ffff;
    return $urandom;
  endfunction

  task automatic push_req(logic [FUNC_W-1:0] f, logic [DATA_W-1:0] v);
    in_item_t r;
    r.func = f;
    r.value = v;
    pending_requests.push_back(r);
  endtask

  // queue random traffic until n_real meaningful requests are in; the mood
  // switches every few dozen requests so the list swings between full and empty
  task automatic queue_random(int n_real);
    int               made;
    int               mode;
    int               left_in_mode;
    int unsigned      pick;
    logic [FUNC_W-1:0] f;
    made = 0;
    mode = MODE_MIXED;
    left_in_mode = 0;
    while (made < n_real) begin
      if (left_in_mode <= 0) begin
        mode = $urandom_range(MODE_DRAIN, MODE_MIXED);
        left_in_mode = $urandom_range(60, 20);
      end
      pick = $urandom_range(99);
      if (pick < 2) begin
        // noise: unused operation codes, ignored by the block
        push_req(FUNC_W'($urandom_range(7, 5)), $urandom);
        left_in_mode--;
      end else if (mode == MODE_DRAIN && pick < 85) begin
        // walk the cursor, then take the node under it
        push_req(($urandom_range(99) < 15) ? F_FIRST : F_NEXT, $urandom);
        push_req(F_REMOVE, $urandom);
        made += 2;
        left_in_mode -= 2;
      end else begin
        pick = $urandom_range(99);
        if (mode == MODE_FILL)
          f = (pick < 40) ? F_INS_TAIL : (pick < 70) ? F_INS_HEAD :
              (pick < 80) ? F_FIRST : (pick < 92) ? F_NEXT : F_REMOVE;
        else
          f = (pick < 20) ? F_INS_TAIL : (pick < 40) ? F_INS_HEAD :
              (pick < 55) ? F_FIRST : (pick < 80) ? F_NEXT : F_REMOVE;
        push_req(f, random_value());
        made++;
        left_in_mode--;
      end
    end
  endtask

  // hold the sender until every queued request is in and every answer is back
  task automatic wait_idle();
    while (pending_requests.size() != 0 || in_valid || expected_results.size() != 0)
      @(negedge clk);
  endtask

  // request driver: a held request stays put while stalled, otherwise the
  // next one goes out unless this cycle is picked as a gap
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!(in_valid && in_stall)) begin
      if (in_valid) begin
        expected_results.push_back(predict_list_op(in_data));
        requests_taken++;
      end
      if (pending_requests.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        in_valid <= 1'b1;
        in_data <= pending_requests.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // result monitor and receiver stall
  always @(posedge clk) begin
    out_item_t exp_res;
    if (rst_n && out_valid && !out_stall) begin
      results_seen++;
      if (out_data.status == S_FULL) full_answers++;
      if (out_data.status == S_NO_CUR) cursor_answers++;
      if (expected_results.size() == 0) begin
        $error("result with nothing outstanding: status %0d data %h count %0d",
               out_data.status, out_data.data_out, out_data.count);
        fail_count++;
      end else begin
        exp_res = expected_results.pop_front();
        if (out_data.status !== exp_res.status) begin
          $error("status expected %0d actual %0d", exp_res.status, out_data.status);
          fail_count++;
        end
        if (out_data.data_out !== exp_res.data_out) begin
          $error("data_out expected %h actual %h", exp_res.data_out, out_data.data_out);
          fail_count++;
        end
        if (out_data.count !== exp_res.count) begin
          $error("count expected %0d actual %0d", exp_res.count, out_data.count);
          fail_count++;
        end
      end
    end
    out_stall <= rst_n && ($urandom_range(99) < recv_stall_pct);
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_count, expected_results.size());
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    int ph;
    // model starts empty with every slot on the free stack
    for (int i = 0; i < DEPTH; i++) begin
      node_val[i] = '0;
      node_nxt[i] = '0;
      free_slots[i] = IDX_W'(DEPTH - 1 - i);
    end
    free_top = DEPTH;
    list_len = 0;
    tail_ptr = '0;
    cur_ptr = '0;
    prev_ptr = '0;
    cur_ok = 1'b0;
    may_remove = 1'b0;

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    for (ph = 0; ph < 4; ph++) begin
      // phases: steady flow, sender gaps, receiver stalls, both
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 48; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 48; end
        default: begin send_idle_pct = 35; recv_stall_pct = 35; end
      endcase
      if (ph == 0) begin
        // cursor and remove on an empty list
        push_req(F_FIRST, 32'h0);
        push_req(F_NEXT, 32'h0);
        push_req(F_REMOVE, 32'h0);
        // one node, no cursor yet
        push_req(F_INS_TAIL, 32'h7fff_ffff);
        push_req(F_NEXT, 32'h0);
        push_req(F_REMOVE, 32'h0);
        // remove the only node, cursor must drop
        push_req(F_FIRST, 32'h0);
        push_req(F_REMOVE, 32'h0);
        push_req(F_INS_HEAD, 32'h8000_0000);
        push_req(F_NEXT, 32'h0);
        push_req(F_INS_TAIL, 32'h0);
        push_req(F_INS_HEAD, 32'hffff_ffff);
        // unused codes
        push_req(3'd5, 32'h1234_5678);
        push_req(3'd6, 32'hffff_ffff);
        push_req(3'd7, 32'h0);
        // an insert takes away the right to remove
        push_req(F_FIRST, 32'h0);
        push_req(F_INS_TAIL, 32'h1);
        push_req(F_REMOVE, 32'h0);
        push_req(F_NEXT, 32'h0);
        push_req(F_REMOVE, 32'h0);
        push_req(F_REMOVE, 32'h0);
        // walk around the ring past the tail
        push_req(F_NEXT, 32'h0);
        push_req(F_NEXT, 32'h0);
        push_req(F_NEXT, 32'h0);
      end
      queue_random(300);
      wait_idle();
    end

    // let anything stray show up before judging
    repeat (TAIL_WAIT) @(negedge clk);
    if (expected_results.size() != 0) begin
      $error("%0d results never arrived", expected_results.size());
      fail_count++;
    end

    $display("covered %0d requests and %0d checked results over four idle mixes",
             requests_taken, results_seen);
    $display("full-list answers %0d, no-cursor answers %0d, %0d cycles",
             full_answers, cursor_answers, cycle_count);
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
